// File: design/assert_macros.svh
// Assertion helpers for the RTL, included by rgbd_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold on every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold on the edge after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/rgbd_pkg.sv
package rgbd_pkg;

  localparam int LED_IDX_W   = 3;
  localparam int LED_REACH   = 1 << LED_IDX_W;
  localparam int NUM_LEDS_DEF = 8;
  localparam int COLOR_W     = 8;
  localparam int DUTY_W      = 16;
  localparam int SLOT_W      = 5;
  localparam int FRAME_BITS  = 24;
  localparam int CFG_IDX_W   = 4;

  localparam logic [DUTY_W-1:0] DUTY_ONE_RST  = 16'd58;
  localparam logic [DUTY_W-1:0] DUTY_ZERO_RST = 16'd29;

  localparam logic [1:0] OP_LOAD     = 2'd0;
  localparam logic [1:0] OP_DIM      = 2'd1;
  localparam logic [1:0] OP_BRIGHTEN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DUTY_ONE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_ZERO = 4'd1;

  localparam logic [COLOR_W-1:0] COLOR_MAX = 8'd255;
  localparam logic [SLOT_W-1:0]  SLOT_LAST = 5'(FRAME_BITS - 1);

  typedef struct packed {
    logic [1:0]           operation;
    logic [LED_IDX_W-1:0] led_index;
    logic [COLOR_W-1:0]   red_in;
    logic [COLOR_W-1:0]   green_in;
    logic [COLOR_W-1:0]   blue_in;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0]    duty_code;
    logic [SLOT_W-1:0]    bit_slot;
    logic [LED_IDX_W-1:0] frame_led;
    logic                 last_code;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic div_step;
    logic apply;
    logic next_k;
    logic write;
    logic emit_adv;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need;
    logic k_last;
    logic div_last;
    logic slot_last;
  } ctrl_sts_t;

  // Smallest nonzero of three levels, zero when all are zero.
  function automatic logic [COLOR_W-1:0] min_nonzero(
    input logic [COLOR_W-1:0] a,
    input logic [COLOR_W-1:0] b,
    input logic [COLOR_W-1:0] c
  );
    logic [COLOR_W-1:0] m;
    m = a;
    if (b != '0 && (m == '0 || b < m)) m = b;
    if (c != '0 && (m == '0 || c < m)) m = c;
    return m;
  endfunction

endpackage

// File: design/rgbd_ctrl.sv
module rgbd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  rgbd_pkg::ctrl_sts_t sts,
  output rgbd_pkg::ctrl_cmd_t cmd
);
  import rgbd_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_APPLY = 6'b001000,
    ST_WRITE = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.need) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end else if (sts.k_last) begin
          state_nxt = ST_WRITE;
        end else begin
          cmd.next_k = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        if (sts.k_last) begin
          state_nxt = ST_WRITE;
        end else begin
          cmd.next_k = 1'b1;
          state_nxt  = ST_CHECK;
        end
      end
      ST_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready) begin
          cmd.emit_adv = 1'b1;
          if (sts.slot_last) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_ALWAYS(a_no_overlap, !(in_ready && out_valid), "accept and emit overlap")
  `ASSERT_NEXT(a_last_to_idle, out_valid && out_ready && sts.slot_last, in_ready, "frame end without idle")
  `ASSERT_NEXT(a_accept_check, in_valid && in_ready, state_r == ST_CHECK, "accept not followed by check")

endmodule

// File: design/rgbd_datapath.sv
module rgbd_datapath #(
  parameter int NUM_LEDS = rgbd_pkg::NUM_LEDS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rgbd_pkg::in_item_t                  in_data,
  output rgbd_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  input  logic [rgbd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rgbd_pkg::DUTY_W-1:0]         cfg_data,
  input  rgbd_pkg::ctrl_cmd_t                 cmd,
  output rgbd_pkg::ctrl_sts_t                 sts
);
  import rgbd_pkg::*;

  // Only the LEDs that the index field can reach get storage.
  localparam int LED_SLOTS = (NUM_LEDS < LED_REACH) ? NUM_LEDS : LED_REACH;
  localparam int ADDR_W    = (LED_SLOTS > 1) ? $clog2(LED_SLOTS) : 1;

  logic [COLOR_W-1:0] base_mem_r [LED_SLOTS][3];
  logic [COLOR_W-1:0] cur_mem_r  [LED_SLOTS][3];

  logic [DUTY_W-1:0]    duty_one_r, duty_zero_r;
  logic [1:0]           op_r;
  logic [LED_IDX_W-1:0] led_r;
  logic [COLOR_W-1:0]   cur_r  [3];
  logic [COLOR_W-1:0]   base_r [3];
  logic [1:0]           k_r;
  logic [COLOR_W-1:0]   dvd_r, dvs_r, quot_r, rem_r;
  logic [2:0]           cnt_r;
  logic [FRAME_BITS-1:0] frame_r;
  logic [SLOT_W-1:0]    slot_r;

  logic               in_range_acc, in_range;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic [COLOR_W-1:0] m_cur, m_base;
  logic [COLOR_W:0]   rem_w;
  logic               rem_ge;
  logic [COLOR_W:0]   sum_w;
  logic               active;

  assign in_range_acc = (32'(in_data.led_index) < NUM_LEDS);
  assign in_range     = (32'(led_r) < NUM_LEDS);
  assign rd_addr      = in_data.led_index[ADDR_W-1:0];
  assign wr_addr      = led_r[ADDR_W-1:0];

  assign m_cur  = min_nonzero(cur_r[0], cur_r[1], cur_r[2]);
  assign m_base = min_nonzero(base_r[0], base_r[1], base_r[2]);
  assign active = in_range && (op_r == OP_DIM || op_r == OP_BRIGHTEN);

  always_comb begin
    sts.need = 1'b0;
    if (active) begin
      if (op_r == OP_DIM) begin
        sts.need = (cur_r[k_r] != '0);
      end else begin
        sts.need = (m_base != '0) && (cur_r[k_r] != COLOR_MAX) && (cur_r[k_r] <= base_r[k_r]);
      end
    end
    sts.k_last    = (k_r == 2'd2);
    sts.div_last  = (cnt_r == 3'd7);
    sts.slot_last = (slot_r == SLOT_LAST);
  end

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign rem_w  = {rem_r, dvd_r[COLOR_W-1]};
  assign rem_ge = (rem_w >= {1'b0, dvs_r});
  assign sum_w  = {1'b0, cur_r[k_r]} + {1'b0, quot_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_one_r  <= DUTY_ONE_RST;
      duty_zero_r <= DUTY_ZERO_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_DUTY_ONE)  duty_one_r  <= cfg_data;
      if (cfg_index == REG_DUTY_ZERO) duty_zero_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LED_SLOTS; i++) begin
        for (int j = 0; j < 3; j++) begin
          base_mem_r[i][j] <= '0;
          cur_mem_r[i][j]  <= '0;
        end
      end
    end else if (cmd.write && in_range) begin
      for (int j = 0; j < 3; j++) begin
        base_mem_r[wr_addr][j] <= base_r[j];
        cur_mem_r[wr_addr][j]  <= cur_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_data.operation;
      led_r <= in_data.led_index;
      k_r   <= 2'd0;
      if (in_range_acc && in_data.operation == OP_LOAD) begin
        cur_r[0]  <= in_data.red_in;
        cur_r[1]  <= in_data.green_in;
        cur_r[2]  <= in_data.blue_in;
        base_r[0] <= in_data.red_in;
        base_r[1] <= in_data.green_in;
        base_r[2] <= in_data.blue_in;
      end else if (in_range_acc) begin
        for (int j = 0; j < 3; j++) begin
          cur_r[j]  <= cur_mem_r[rd_addr][j];
          base_r[j] <= base_mem_r[rd_addr][j];
        end
      end else begin
        for (int j = 0; j < 3; j++) begin
          cur_r[j]  <= '0;
          base_r[j] <= '0;
        end
      end
    end
    if (cmd.next_k) k_r <= k_r + 2'd1;
    if (cmd.div_start) begin
      dvd_r <= (op_r == OP_DIM) ? cur_r[k_r] : base_r[k_r];
      dvs_r <= (op_r == OP_DIM) ? m_cur : m_base;
      rem_r <= '0;
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r  <= rem_ge ? 8'(rem_w - {1'b0, dvs_r}) : rem_w[COLOR_W-1:0];
      quot_r <= {quot_r[COLOR_W-2:0], rem_ge};
      dvd_r  <= {dvd_r[COLOR_W-2:0], 1'b0};
      cnt_r  <= cnt_r + 3'd1;
    end
    if (cmd.apply) begin
      if (op_r == OP_DIM) begin
        cur_r[k_r] <= cur_r[k_r] - quot_r;
      end else begin
        cur_r[k_r] <= sum_w[COLOR_W] ? COLOR_MAX : sum_w[COLOR_W-1:0];
      end
    end
    if (cmd.write) begin
      frame_r <= in_range ? {cur_r[1], cur_r[0], cur_r[2]} : '0;
      slot_r  <= '0;
    end
    if (cmd.emit_adv) begin
      frame_r <= {frame_r[FRAME_BITS-2:0], 1'b0};
      slot_r  <= slot_r + 5'd1;
    end
  end

  assign out_data.duty_code = frame_r[FRAME_BITS-1] ? duty_one_r : duty_zero_r;
  assign out_data.bit_slot  = slot_r;
  assign out_data.frame_led = led_r;
  assign out_data.last_code = (slot_r == SLOT_LAST);

endmodule

// File: design/rgb_led_dimmer_with_bit_encoder.sv
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid / in_ready    | in_data   (operation, LED, R, G, B)
// out     | output    | out_valid / out_ready  | out_data  (duty code, slot, LED, last)
// cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data (duty_one, duty_zero)
//
// One item at a time. A load or out-of-range item goes from accept through the component
// checks, write back and emit; dim and brighten also run the shared divider once per
// component needing an update (check, divide, apply; a component left alone only checks).
// The 24 codes leave one per cycle while out_ready is high; a stall holds the code.
// Synchronous reset clears every entry of the color store and restores the duty codes.
// cfg_ready is always high; write registers only while the block is idle.
module rgb_led_dimmer_with_bit_encoder #(
  parameter int NUM_LEDS = rgbd_pkg::NUM_LEDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  rgbd_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output rgbd_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rgbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rgbd_pkg::DUTY_W-1:0]    cfg_data
);
  import rgbd_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Register writes never stall.
  assign cfg_ready = 1'b1;

  // Sequence the item: accept, per-component divide and update, write back, emit.
  rgbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold the color store, the working triple, the divider and the frame shifter.
  rgbd_datapath #(
    .NUM_LEDS (NUM_LEDS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
